/* hw/rtl/tsched_pkg.sv */
// Shared types and constants of the task scheduler.
package tsched_pkg;

    // Field widths
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 32;
    localparam int Q_W       = 16;
    localparam int TC_W      = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [Q_W-1:0]  QUANTUM_RESET    = 16'd500;
    localparam logic [TC_W-1:0] TASK_COUNT_RESET = 5'd16;

    // Command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Policy codes
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_SJF  = 2'd2;
    localparam logic [1:0] POL_PSJF = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd2;

    // Slot scan modes
    localparam logic [1:0] MODE_FIRST = 2'd0;  // first eligible in scan order
    localparam logic [1:0] MODE_ARR   = 2'd1;  // earliest arrival
    localparam logic [1:0] MODE_REM   = 2'd2;  // smallest remaining time
    localparam logic [1:0] MODE_COUNT = 2'd3;  // count finished slots

    // Commands from controller to datapath
    typedef struct packed {
        logic       accept;
        logic       load;
        logic       restart;
        logic       scan_start;
        logic       scan_zero;
        logic [1:0] scan_mode;
        logic       scan_step;
        logic       cur_check;
        logic       pick_cur;
        logic       wrap_init;
        logic       wrap_step;
        logic       apply;
        logic       capture;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       all_done;
        logic       out_free;
        logic       retire_last;
        logic       cv_after;
        logic       slice_zero;
        logic       rem_zero;
        logic       wrap_ok;
        logic       scan_done;
        logic [1:0] policy;
    } t_dp_stat;

endpackage

/* hw/rtl/tsched_ctrl.sv */
// Sequencing state machine of the task scheduler.
module tsched_ctrl import tsched_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_cmd,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_WRAP  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_COUNT = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Decode state into datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    case (i_cmd)
                        CMD_LOAD: begin
                            o_ctl.load = 1'b1;
                            n_state    = S_OUT;
                        end
                        CMD_RESTART: begin
                            o_ctl.restart    = 1'b1;
                            o_ctl.scan_start = 1'b1;
                            o_ctl.scan_zero  = 1'b1;
                            o_ctl.scan_mode  = MODE_COUNT;
                            n_state          = S_COUNT;
                        end
                        CMD_TICK: begin
                            n_state = i_stat.all_done ? S_OUT : S_CHK;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_CHK: begin
                o_ctl.cur_check = 1'b1;
                if (i_stat.retire_last) begin
                    n_state = S_OUT;
                end else begin
                    case (i_stat.policy)
                        POL_FIFO, POL_SJF: begin
                            if (i_stat.cv_after) begin
                                o_ctl.pick_cur = 1'b1;
                                n_state        = S_APPLY;
                            end else begin
                                o_ctl.scan_start = 1'b1;
                                o_ctl.scan_zero  = 1'b1;
                                o_ctl.scan_mode  = (i_stat.policy == POL_FIFO) ?
                                                   MODE_ARR : MODE_REM;
                                n_state          = S_SCAN;
                            end
                        end
                        POL_RR: begin
                            if (!i_stat.cv_after) begin
                                o_ctl.scan_start = 1'b1;
                                o_ctl.scan_zero  = 1'b1;
                                o_ctl.scan_mode  = MODE_FIRST;
                                n_state          = S_SCAN;
                            end else if (i_stat.slice_zero || i_stat.rem_zero) begin
                                o_ctl.wrap_init = 1'b1;
                                n_state         = S_WRAP;
                            end else begin
                                o_ctl.pick_cur = 1'b1;
                                n_state        = S_APPLY;
                            end
                        end
                        default: begin
                            o_ctl.scan_start = 1'b1;
                            o_ctl.scan_zero  = 1'b1;
                            o_ctl.scan_mode  = MODE_REM;
                            n_state          = S_SCAN;
                        end
                    endcase
                end
            end
            S_WRAP: begin
                // reduce the start slot below the slot count, then scan from it
                o_ctl.wrap_step = 1'b1;
                if (i_stat.wrap_ok) begin
                    o_ctl.scan_start = 1'b1;
                    o_ctl.scan_mode  = MODE_FIRST;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_APPLY;
                end
            end
            S_COUNT: begin
                o_ctl.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_APPLY: begin
                if (i_stat.out_free) begin
                    o_ctl.apply   = 1'b1;
                    o_ctl.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/tsched_dp.sv */
// Datapath of the task scheduler: slot tables, scan unit, task state, result register.
module tsched_dp import tsched_pkg::*; #(
    parameter int MAX_TASKS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [TIME_W-1:0]    i_arrival,
    input  logic [TIME_W-1:0]    i_run_length,
    input  logic                 i_out_ready,
    input  t_dp_cmd              i_ctl,
    output t_dp_stat             o_stat,
    output logic                 o_out_valid,
    output logic                 o_running_valid,
    output logic [SLOT_W-1:0]    o_running_slot,
    output logic                 o_switched,
    output logic                 o_finished_valid,
    output logic [SLOT_W-1:0]    o_finished_slot,
    output logic                 o_all_done,
    output logic [TIME_W-1:0]    o_now
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CMP_W = (CNT_W > TC_W) ? CNT_W : TC_W;

    // Slot tables
    logic [TIME_W-1:0] mem_arr [MAX_TASKS];
    logic [TIME_W-1:0] mem_rem [MAX_TASKS];
    logic [TIME_W-1:0] r_rd_arr;
    logic [TIME_W-1:0] r_rd_rem;

    // Configuration
    logic [1:0]      r_policy;
    logic [Q_W-1:0]  r_quantum;
    logic [TC_W-1:0] r_task_count;

    // Task state
    logic             r_cur_valid;
    logic [IDX_W-1:0] r_cur_slot;
    logic [TIME_W-1:0] r_tick;
    logic [Q_W-1:0]   r_slice;
    logic [CNT_W-1:0] r_done;
    logic             r_fin_v;
    logic [IDX_W-1:0] r_fin_slot;

    // Scan unit
    logic [CNT_W-1:0] r_iter;
    logic [CNT_W-1:0] r_left;
    logic [1:0]       r_mode;
    logic             r_eval_v;
    logic [IDX_W-1:0] r_eval_idx;
    logic             r_best_v;
    logic [IDX_W-1:0] r_best_idx;
    logic [TIME_W-1:0] r_best_rem;
    logic [TIME_W-1:0] r_best_key;

    // Result register
    logic              r_out_valid;
    logic              r_out_run_v;
    logic [SLOT_W-1:0] r_out_run_slot;
    logic              r_out_sw;
    logic              r_out_fin_v;
    logic [SLOT_W-1:0] r_out_fin_slot;
    logic              r_out_all_done;
    logic [TIME_W-1:0] r_out_now;

    logic [CMP_W-1:0] tc_ext;
    logic [CMP_W-1:0] n_cmp;
    logic [CNT_W-1:0] n_slots;
    logic             issue;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] iter_inc;
    logic             slot_ok;
    logic             we_load;
    logic             we_dec;
    logic             elig;
    logic             better;
    logic             take;
    logic             cnt_inc;
    logic             retire;
    logic [CNT_W-1:0] done_inc;
    logic             last;
    logic             all_done;
    logic             sw_new;
    logic [Q_W-1:0]   q_eff;
    logic [Q_W:0]     slice_inc;
    logic [Q_W-1:0]   slice_next;
    logic             out_free;

    // Slots in use: task count saturated at the table depth
    always_comb begin
        tc_ext  = CMP_W'(r_task_count);
        n_cmp   = (tc_ext > CMP_W'(MAX_TASKS)) ? CMP_W'(MAX_TASKS) : tc_ext;
        n_slots = CNT_W'(n_cmp);
    end

    // Table port: scan address while scanning, else the current slot
    assign issue    = i_ctl.scan_step && (r_left != '0);
    assign rd_addr  = issue ? r_iter[IDX_W-1:0] : r_cur_slot;
    assign iter_inc = r_iter + 1'b1;
    assign slot_ok  = (32'(i_slot) < 32'(MAX_TASKS));
    assign we_load  = i_ctl.load && slot_ok;
    assign we_dec   = i_ctl.apply && r_best_v && (r_best_rem != '0);

    always_ff @(posedge i_clk) begin
        if (we_load) begin
            mem_arr[IDX_W'(i_slot)] <= i_arrival;
            mem_rem[IDX_W'(i_slot)] <= i_run_length;
        end else if (we_dec) begin
            mem_rem[r_best_idx] <= r_best_rem - 1'b1;
        end
        r_rd_arr <= mem_arr[rd_addr];
        r_rd_rem <= mem_rem[rd_addr];
    end

    // Evaluate the slot read in the previous cycle
    always_comb begin
        elig = (r_rd_arr <= r_tick) && (r_rd_rem != '0);
        case (r_mode)
            MODE_FIRST: better = !r_best_v;
            MODE_ARR:   better = !r_best_v || (r_rd_arr < r_best_key);
            MODE_REM:   better = !r_best_v || (r_rd_rem < r_best_key);
            default:    better = 1'b0;
        endcase
        take    = r_eval_v && elig && better;
        cnt_inc = r_eval_v && (r_mode == MODE_COUNT) && (r_rd_rem == '0);
    end

    // Retirement of the current task
    assign retire   = r_cur_valid && (r_rd_rem == '0);
    assign done_inc = r_done + 1'b1;
    assign last     = (done_inc >= n_slots);
    assign all_done = (r_done >= n_slots);

    // Dispatch and slice update
    always_comb begin
        sw_new     = r_best_v && (!r_cur_valid || (r_cur_slot != r_best_idx));
        q_eff      = (r_quantum == '0) ? Q_W'(1) : r_quantum;
        slice_inc  = {1'b0, (sw_new ? '0 : r_slice)} + 1'b1;
        slice_next = (slice_inc >= {1'b0, q_eff}) ? '0 : slice_inc[Q_W-1:0];
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Status to controller
    always_comb begin
        o_stat             = '0;
        o_stat.all_done    = all_done;
        o_stat.out_free    = out_free;
        o_stat.retire_last = retire && last;
        o_stat.cv_after    = r_cur_valid && !(retire && (r_policy != POL_RR));
        o_stat.slice_zero  = (r_slice == '0);
        o_stat.rem_zero    = (r_rd_rem == '0);
        o_stat.wrap_ok     = (r_iter < n_slots);
        o_stat.scan_done   = (r_left == '0) && !r_eval_v;
        o_stat.policy      = r_policy;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_FIFO;
            r_quantum    <= QUANTUM_RESET;
            r_task_count <= TASK_COUNT_RESET;
            r_cur_valid  <= 1'b0;
            r_cur_slot   <= '0;
            r_tick       <= '0;
            r_slice      <= '0;
            r_done       <= '0;
            r_fin_v      <= 1'b0;
            r_left       <= '0;
            r_eval_v     <= 1'b0;
            r_best_v     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY:     r_policy     <= i_cfg_data[1:0];
                    CFG_QUANTUM:    r_quantum    <= i_cfg_data[Q_W-1:0];
                    CFG_TASK_COUNT: r_task_count <= i_cfg_data[TC_W-1:0];
                    default: ;
                endcase
            end

            if (i_ctl.accept) begin
                r_fin_v <= 1'b0;
            end

            // restart at time zero
            if (i_ctl.restart) begin
                r_tick      <= '0;
                r_slice     <= '0;
                r_cur_valid <= 1'b0;
                r_cur_slot  <= '0;
                r_done      <= '0;
            end

            // scan control
            if (i_ctl.scan_start) begin
                r_left   <= n_slots;
                r_mode   <= i_ctl.scan_mode;
                r_best_v <= 1'b0;
                r_eval_v <= 1'b0;
                if (i_ctl.scan_zero) begin
                    r_iter <= '0;
                end
            end
            if (i_ctl.scan_step) begin
                if (issue) begin
                    r_eval_v   <= 1'b1;
                    r_eval_idx <= r_iter[IDX_W-1:0];
                    r_iter     <= (iter_inc == n_slots) ? '0 : iter_inc;
                    r_left     <= r_left - 1'b1;
                end else begin
                    r_eval_v <= 1'b0;
                end
            end
            if (take) begin
                r_best_v   <= 1'b1;
                r_best_idx <= r_eval_idx;
                r_best_rem <= r_rd_rem;
                r_best_key <= (r_mode == MODE_ARR) ? r_rd_arr : r_rd_rem;
            end
            if (cnt_inc) begin
                r_done <= done_inc;
            end

            // retire the current task
            if (i_ctl.cur_check && retire) begin
                r_fin_v    <= 1'b1;
                r_fin_slot <= r_cur_slot;
                r_done     <= done_inc;
                if (last || (r_policy != POL_RR)) begin
                    r_cur_valid <= 1'b0;
                end
                if (last) begin
                    r_cur_slot <= '0;
                end
            end

            // keep the current task
            if (i_ctl.pick_cur) begin
                r_best_v   <= 1'b1;
                r_best_idx <= r_cur_slot;
                r_best_rem <= r_rd_rem;
            end

            // round robin start slot
            if (i_ctl.wrap_init) begin
                r_iter <= CNT_W'(r_cur_slot) + 1'b1;
            end
            if (i_ctl.wrap_step && (r_iter >= n_slots)) begin
                r_iter <= r_iter - n_slots;
            end

            // dispatch and advance time
            if (i_ctl.apply) begin
                r_cur_valid <= r_best_v;
                r_cur_slot  <= r_best_v ? r_best_idx : '0;
                r_tick      <= r_tick + 1'b1;
                if (r_best_v) begin
                    r_slice <= slice_next;
                end
            end

            // result register
            if (i_ctl.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            if (i_ctl.apply) begin
                r_out_run_v    <= r_best_v;
                r_out_run_slot <= r_best_v ? SLOT_W'(r_best_idx) : '0;
                r_out_sw       <= sw_new;
            end else begin
                r_out_run_v    <= r_cur_valid;
                r_out_run_slot <= r_cur_valid ? SLOT_W'(r_cur_slot) : '0;
                r_out_sw       <= 1'b0;
            end
            r_out_fin_v    <= r_fin_v;
            r_out_fin_slot <= r_fin_v ? SLOT_W'(r_fin_slot) : '0;
            r_out_all_done <= all_done;
            r_out_now      <= r_tick;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_running_valid  = r_out_run_v;
    assign o_running_slot   = r_out_run_slot;
    assign o_switched       = r_out_sw;
    assign o_finished_valid = r_out_fin_v;
    assign o_finished_slot  = r_out_fin_slot;
    assign o_all_done       = r_out_all_done;
    assign o_now            = r_out_now;

endmodule

/* hw/rtl/task_scheduler_fifo_rr_sjf_psjf.sv */
// Task scheduler top level: controller and datapath.
//
// Usage: load task slots (cmd load, with slot, arrival and run length), in
// order of arrival, then send a restart and one tick command per timer tick.
// Every accepted command returns exactly one result on the output channel:
// the running task, whether a new task was dispatched, the task retired at
// this tick, the all-done flag and the tick number. Policy, quantum and task
// count are written through the plain write port while the block is idle.
// Slot scan (n = slots in use): a tick that picks anew waits on the slot
// scan, which reads one table entry per cycle; when round robin restarts
// its scan from a slot at or beyond n, the start slot is first reduced
// by n, one wrap per step. A restart also scans the n slots to count the
// finished ones. One command is in work at a time; the next is taken once
// the current one has reached the result register, so a new command may
// enter while the last result still waits. Reset clears the task state,
// time and result register and sets policy fifo, quantum 500 and task
// count 16; slot tables keep their contents.
// If the receiver stalls, the finished result holds and the block waits.
module task_scheduler_fifo_rr_sjf_psjf import tsched_pkg::*; #(
    parameter int MAX_TASKS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [TIME_W-1:0]    i_arrival,
    input  logic [TIME_W-1:0]    i_run_length,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_running_valid,
    output logic [SLOT_W-1:0]    o_running_slot,
    output logic                 o_switched,
    output logic                 o_finished_valid,
    output logic [SLOT_W-1:0]    o_finished_slot,
    output logic                 o_all_done,
    output logic [TIME_W-1:0]    o_now
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    // Sequencer
    tsched_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // Tables, scan unit and result register
    tsched_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_slot           (i_slot),
        .i_arrival        (i_arrival),
        .i_run_length     (i_run_length),
        .i_out_ready      (i_out_ready),
        .i_ctl            (ctl),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_running_valid  (o_running_valid),
        .o_running_slot   (o_running_slot),
        .o_switched       (o_switched),
        .o_finished_valid (o_finished_valid),
        .o_finished_slot  (o_finished_slot),
        .o_all_done       (o_all_done),
        .o_now            (o_now)
    );

endmodule

/* dv/tb_task_scheduler_fifo_rr_sjf_psjf.sv */
// Self-checking testbench of the task scheduler: directed and random command streams.
`timescale 1ns / 1ps

module tb_task_scheduler_fifo_rr_sjf_psjf;
    import tsched_pkg::*;

    localparam int MAX_TASKS = 16;
    // Command code outside the defined set; the block answers it with a status
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic              running_valid;
        logic [SLOT_W-1:0] running_slot;
        logic              switched;
        logic              finished_valid;
        logic [SLOT_W-1:0] finished_slot;
        logic              all_done;
        logic [TIME_W-1:0] now;
    } sched_status_t;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_cmd        = CMD_LOAD;
    logic [SLOT_W-1:0]    i_slot       = '0;
    logic [TIME_W-1:0]    i_arrival    = '0;
    logic [TIME_W-1:0]    i_run_length = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b1;
    logic                 o_running_valid;
    logic [SLOT_W-1:0]    o_running_slot;
    logic                 o_switched;
    logic                 o_finished_valid;
    logic [SLOT_W-1:0]    o_finished_slot;
    logic                 o_all_done;
    logic [TIME_W-1:0]    o_now;

    // Expected status words, oldest first
    sched_status_t status_due[$];

    int items_sent    = 0;
    int err_cnt       = 0;
    int in_gap_pct    = 25;
    int out_stall_pct = 25;

    // Scheduler state as the testbench tracks it
    logic [1:0]        reg_policy     = POL_FIFO;
    logic [Q_W-1:0]    reg_quantum    = QUANTUM_RESET;
    logic [TC_W-1:0]   reg_task_count = TASK_COUNT_RESET;
    logic [TIME_W-1:0] tsk_arrival [MAX_TASKS];
    logic [TIME_W-1:0] tsk_left    [MAX_TASKS];
    logic              cur_valid      = 1'b0;
    logic [SLOT_W-1:0] cur_slot       = '0;
    logic [TIME_W-1:0] tick_now       = '0;
    int unsigned       slice_cnt      = 0;
    int unsigned       done_cnt       = 0;

    task_scheduler_fifo_rr_sjf_psjf #(
        .MAX_TASKS(MAX_TASKS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_slot          (i_slot),
        .i_arrival       (i_arrival),
        .i_run_length    (i_run_length),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_running_valid (o_running_valid),
        .o_running_slot  (o_running_slot),
        .o_switched      (o_switched),
        .o_finished_valid(o_finished_valid),
        .o_finished_slot (o_finished_slot),
        .o_all_done      (o_all_done),
        .o_now           (o_now)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Scheduling predictor
    // ------------------------------------------------------------------

    function automatic int slots_used();
        return (reg_task_count > MAX_TASKS) ? MAX_TASKS : int'(reg_task_count);
    endfunction

    function automatic bit task_ready(int i);
        return i < slots_used() && tsk_arrival[i] <= tick_now && tsk_left[i] != 0;
    endfunction

    function automatic bit all_finished();
        return done_cnt >= slots_used();
    endfunction

    // Earliest arrival, or smallest remaining time; lowest slot wins ties
    function automatic int pick_best(bit by_left);
        int best;
        int n;
        best = -1;
        n = slots_used();
        for (int i = 0; i < n; i++) begin
            if (!task_ready(i))
                continue;
            if (best < 0)
                best = i;
            else if (!by_left && tsk_arrival[i] < tsk_arrival[best])
                best = i;
            else if (by_left && tsk_left[i] < tsk_left[best])
                best = i;
        end
        return best;
    endfunction

    // Keep the current task until its slice expires or it retires, then scan on
    function automatic int pick_round_robin();
        int n;
        int idx;
        n = slots_used();
        if (!cur_valid) begin
            for (int i = 0; i < n; i++)
                if (task_ready(i))
                    return i;
            return -1;
        end
        if (slice_cnt == 0 || tsk_left[cur_slot] == 0) begin
            if (n == 0)
                return -1;
            for (int k = 1; k <= n; k++) begin
                idx = (int'(cur_slot) + k) % n;
                if (task_ready(idx))
                    return idx;
            end
            return -1;
        end
        return int'(cur_slot);
    endfunction

    function automatic sched_status_t make_status(logic sw, logic fv, logic [SLOT_W-1:0] fs);
        sched_status_t st;
        st.running_valid  = cur_valid;
        st.running_slot   = cur_valid ? cur_slot : '0;
        st.switched       = sw;
        st.finished_valid = fv;
        st.finished_slot  = fv ? fs : '0;
        st.all_done       = all_finished();
        st.now            = tick_now;
        return st;
    endfunction

    // Apply one command to the tracked state and return the status it causes
    function automatic sched_status_t schedule_step(logic [1:0] cmd, logic [SLOT_W-1:0] slot,
                                                    logic [TIME_W-1:0] arr,
                                                    logic [TIME_W-1:0] len);
        int            n;
        int            nxt;
        logic          fv;
        logic          sw;
        logic [SLOT_W-1:0] fs;
        int unsigned   q;
        sched_status_t st;
        fv = 1'b0;
        sw = 1'b0;
        fs = '0;
        if (cmd == CMD_LOAD) begin
            tsk_arrival[slot] = arr;
            tsk_left[slot]    = len;
            return make_status(1'b0, 1'b0, '0);
        end
        if (cmd == CMD_RESTART) begin
            n         = slots_used();
            tick_now  = '0;
            slice_cnt = 0;
            cur_valid = 1'b0;
            cur_slot  = '0;
            done_cnt  = 0;
            for (int i = 0; i < n; i++)
                if (tsk_left[i] == 0)
                    done_cnt++;
            return make_status(1'b0, 1'b0, '0);
        end
        if (cmd != CMD_TICK || all_finished())
            return make_status(1'b0, 1'b0, '0);

        // Retire the running task once its work is used up
        if (cur_valid && tsk_left[cur_slot] == 0) begin
            fv = 1'b1;
            fs = cur_slot;
            if (reg_policy != POL_RR)
                cur_valid = 1'b0;
            done_cnt++;
            if (all_finished()) begin
                cur_valid = 1'b0;
                cur_slot  = '0;
                return make_status(1'b0, fv, fs);
            end
        end

        case (reg_policy)
            POL_FIFO: nxt = cur_valid ? int'(cur_slot) : pick_best(1'b0);
            POL_RR:   nxt = pick_round_robin();
            POL_SJF:  nxt = cur_valid ? int'(cur_slot) : pick_best(1'b1);
            default:  nxt = pick_best(1'b1);  // preemptive: rescan every tick
        endcase

        if (nxt < 0) begin
            cur_valid = 1'b0;
            cur_slot  = '0;
        end else begin
            if (!cur_valid || int'(cur_slot) != nxt) begin
                sw        = 1'b1;
                slice_cnt = 0;
            end
            cur_valid = 1'b1;
            cur_slot  = nxt;
        end
        st = make_status(sw, fv, fs);

        // Advance time and take one tick of work
        tick_now++;
        if (cur_valid) begin
            q = (reg_quantum == 0) ? 1 : reg_quantum;
            slice_cnt++;
            if (slice_cnt >= q)
                slice_cnt = 0;
            if (tsk_left[cur_slot] != 0)
                tsk_left[cur_slot]--;
        end
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                   logic [TIME_W-1:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic check_result(sched_status_t got);
        sched_status_t want;
        if (status_due.size() == 0) begin
            report_mismatch("result with nothing pending, now", got.now, '0);
            return;
        end
        want = status_due.pop_front();
        if (got.running_valid !== want.running_valid)
            report_mismatch("running_valid", got.running_valid, want.running_valid);
        if (got.running_slot !== want.running_slot)
            report_mismatch("running_slot", got.running_slot, want.running_slot);
        if (got.switched !== want.switched)
            report_mismatch("switched", got.switched, want.switched);
        if (got.finished_valid !== want.finished_valid)
            report_mismatch("finished_valid", got.finished_valid, want.finished_valid);
        if (got.finished_slot !== want.finished_slot)
            report_mismatch("finished_slot", got.finished_slot, want.finished_slot);
        if (got.all_done !== want.all_done)
            report_mismatch("all_done", got.all_done, want.all_done);
        if (got.now !== want.now)
            report_mismatch("now", got.now, want.now);
    endtask

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_result({o_running_valid, o_running_slot, o_switched, o_finished_valid,
                          o_finished_slot, o_all_done, o_now});
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one command, hold it until the transfer, then predict its status
    task automatic send_cmd(logic [1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [TIME_W-1:0] arr, logic [TIME_W-1:0] len);
        @(negedge i_clk);
        while (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_slot       <= slot;
        i_arrival    <= arr;
        i_run_length <= len;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        status_due.push_back(schedule_step(cmd, slot, arr, len));
        items_sent++;
    endtask

    task automatic send_tick();
        send_cmd(CMD_TICK, $urandom, $urandom, $urandom);
    endtask

    // Drop valid and hold off until every pending status has come back
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_POLICY:     reg_policy     = data[1:0];
            CFG_QUANTUM:    reg_quantum    = data;
            CFG_TASK_COUNT: reg_task_count = data[TC_W-1:0];
            default: ;  // unmapped index holds nothing
        endcase
    endtask

    // Program all registers once the block is idle; upper bits carry noise
    task automatic set_config(logic [1:0] pol, logic [Q_W-1:0] q, logic [TC_W-1:0] tc);
        logic [CFG_W-1:0] hi;
        wait_drain();
        hi = $urandom;
        write_reg(CFG_POLICY, {hi[CFG_W-1:2], pol});
        write_reg(CFG_QUANTUM, q);
        hi = $urandom;
        write_reg(CFG_TASK_COUNT, {hi[CFG_W-1:TC_W], tc});
    endtask

    function automatic logic [Q_W-1:0] rand_quantum();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 30)
            return $urandom;
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [TC_W-1:0] rand_task_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 15)
            return $urandom_range(MAX_TASKS + 1, 31);
        if (r < 25)
            return MAX_TASKS;
        return $urandom_range(1, 6);
    endfunction

    // One workload: load in arrival order, restart, tick until all done
    task automatic run_workload(logic [1:0] pol, logic [Q_W-1:0] q, logic [TC_W-1:0] tc,
                                bit long_jobs);
        int                n;
        int                cap;
        int                sum_len;
        int                r;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] len;
        set_config(pol, q, tc);
        n       = (tc > MAX_TASKS) ? MAX_TASKS : int'(tc);
        arr     = $urandom_range(0, 2);
        sum_len = 0;
        for (int i = 0; i < n; i++) begin
            if (long_jobs)
                len = $urandom;
            else
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            if (!long_jobs)
                sum_len += int'(len);
            send_cmd(CMD_LOAD, i, arr, len);
            arr += $urandom_range(0, 3);
        end
        send_cmd(CMD_RESTART, $urandom, $urandom, $urandom);
        cap = long_jobs ? 40 : int'(arr) + sum_len + 8;
        // Mostly ticks; now and then a stray command or a full pause
        for (int t = 0; t < cap && !all_finished(); t++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_cmd(CMD_UNUSED, $urandom, $urandom, $urandom);
            end else if (r < 6) begin
                send_cmd(CMD_LOAD, $urandom, $urandom_range(0, 20), $urandom_range(0, 6));
            end else begin
                if (r < 8)
                    wait_drain();
                send_tick();
            end
        end
        // A tick after completion must change nothing
        send_tick();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill every slot; slot 0 holds no work, slot 15 the largest values
    task automatic test_load_extremes();
        for (int i = 0; i < MAX_TASKS - 1; i++)
            send_cmd(CMD_LOAD, i, i, (i == 0) ? 0 : (i % 3) + 1);
        send_cmd(CMD_LOAD, MAX_TASKS - 1, '1, '1);
    endtask

    // Restart, ticks, an undefined command, a load between ticks, a full pause
    task automatic test_commands();
        send_cmd(CMD_RESTART, '0, '0, '0);
        send_tick();
        send_tick();
        send_cmd(CMD_UNUSED, '1, '1, '1);
        send_cmd(CMD_LOAD, 14, 14, 2);
        wait_drain();
        send_tick();
    endtask

    // Unmapped index, zero task count, saturated task count, zero quantum
    task automatic test_register_edges();
        wait_drain();
        write_reg(CFG_IDX_W'(3), '1);
        set_config(POL_RR, '0, '0);
        send_tick();
        set_config(POL_PSJF, '1, 5'd31);
        send_cmd(CMD_RESTART, '0, '0, '0);
        send_tick();
        set_config(POL_RR, '0, 5'd3);
        send_cmd(CMD_RESTART, '0, '0, '0);
        send_tick();
        send_tick();
    endtask

    // Random workloads with both channels always ready
    task automatic test_steady_stream(int target);
        in_gap_pct    = 0;
        out_stall_pct = 0;
        while (items_sent < target)
            run_workload($urandom_range(0, 3), rand_quantum(), rand_task_count(), 1'b0);
        in_gap_pct    = 25;
        out_stall_pct = 25;
    endtask

    // Random workloads under idling on both sides
    task automatic test_random_workloads(int target);
        while (items_sent < target)
            run_workload($urandom_range(0, 3), rand_quantum(), rand_task_count(),
                         $urandom_range(0, 14) == 0);
    endtask

    // Unstructured command mix with full-range fields
    task automatic test_noise_commands(int count);
        int r;
        for (int k = 0; k < count; k++) begin
            if (k % 25 == 0)
                set_config($urandom_range(0, 3), rand_quantum(), rand_task_count());
            r = $urandom_range(0, 99);
            if (r < 15)
                send_cmd(CMD_LOAD, $urandom, $urandom, $urandom);
            else if (r < 30)
                send_cmd(CMD_LOAD, $urandom, $urandom_range(0, 30), $urandom_range(0, 8));
            else if (r < 40)
                send_cmd(CMD_RESTART, $urandom, $urandom, $urandom);
            else if (r < 48)
                send_cmd(CMD_UNUSED, $urandom, $urandom, $urandom);
            else
                send_tick();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_load_extremes();
        test_commands();
        test_register_edges();
        test_steady_stream(330);
        test_random_workloads(980);
        test_noise_commands(100);

        // Let the last results drain, then watch for stray transfers
        wait_drain();
        repeat (60) @(posedge i_clk);
        if (status_due.size() != 0)
            report_mismatch("statuses never returned", status_due.size(), '0);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Abort a hung run
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
